// File: src/udiv128_pkg.sv
// shared types and constants for the 128-bit unsigned divider
// no dependencies
`timescale 1ns / 1ps

package udiv128_pkg;

    localparam int WORD_W  = 64;
    localparam int NUM_W   = 2 * WORD_W;
    localparam int TDATA_W = 4 * WORD_W;
    localparam int CNT_W   = $clog2(NUM_W);

    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(NUM_W - 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DONE
    } udiv128_state_t;

    typedef struct packed {
        logic load;
        logic step;
        logic out_load;
    } udiv128_cmd_t;

endpackage

// File: src/udiv128_quotient_remainder.sv
// Unsigned 128-bit divider, quotient and remainder of one item at a time.
//
// Input channel s_axis: tdata carries dividend and divisor, 64-bit words,
// low word first. Output channel m_axis: tdata carries quotient and
// remainder in the same layout, tuser flags a zero divisor, in which case
// quotient and remainder are all zero.
// An accepted item runs 128 steps of a radix-2 shift-subtract loop, one
// quotient bit per clock through a single 130-bit subtract and compare.
// The result goes to the output register once the loop is done; a new item
// is accepted only after the previous one has left the loop.
// Finished results sit in an output register, so the next item is taken
// in while the previous result still waits. If the receiver stalls long
// enough, the loop holds its finished result until the output register
// frees up and s_axis_tready stays low meanwhile.
// Reset (rst_n, asynchronous, active low) empties the loop and the output
// register; s_axis_tready stays low during reset and an item can be taken
// at the first clock edge after reset is released.
// depends on udiv128_pkg, udiv128_ctrl, udiv128_dp
`timescale 1ns / 1ps

module udiv128_quotient_remainder
    import udiv128_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    // dividend_low, dividend_high, divisor_low, divisor_high
    input  logic [TDATA_W-1:0] s_axis_tdata,
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    // quotient_low, quotient_high, remainder_low, remainder_high
    output logic [TDATA_W-1:0] m_axis_tdata,
    // zero_divisor
    output logic               m_axis_tuser
);

    udiv128_cmd_t cmd;

    udiv128_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .cmd       (cmd)
    );

    udiv128_dp u_dp (
        .clk      (clk),
        .cmd      (cmd),
        .in_data  (s_axis_tdata),
        .out_data (m_axis_tdata),
        .out_zero (m_axis_tuser)
    );

`ifndef SYNTHESIS
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0)
        else $error("zero divisor result carries nonzero data");

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |-> s_axis_tvalid && s_axis_tready)
        else $error("load without input accept");

    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input still ready after accept");

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |=> m_axis_tvalid)
        else $error("output not valid after result load");
`endif

endmodule

// File: src/udiv128_dp.sv
// datapath of the divider: shift-subtract remainder, quotient and result registers
// depends on udiv128_pkg
`timescale 1ns / 1ps

module udiv128_dp
    import udiv128_pkg::*;
(
    input  logic                clk,
    input  udiv128_cmd_t        cmd,
    input  logic [TDATA_W-1:0]  in_data,
    output logic [TDATA_W-1:0]  out_data,
    output logic                out_zero
);

    logic [NUM_W-1:0] rem_reg;
    logic [NUM_W-1:0] rem_next;
    logic [NUM_W-1:0] quo_reg;
    logic [NUM_W-1:0] quo_next;
    logic [NUM_W-1:0] dvs_reg;
    logic [NUM_W-1:0] dvs_next;
    logic             zero_reg;
    logic             zero_next;
    logic [TDATA_W-1:0] res_reg;
    logic [TDATA_W-1:0] res_next;
    logic             res_zero_reg;
    logic             res_zero_next;

    logic [NUM_W:0]   shifted;
    logic [NUM_W+1:0] diff;
    logic             take;

    // shift in the next dividend bit and try the subtraction
    assign shifted = {rem_reg, quo_reg[NUM_W-1]};
    assign diff    = {1'b0, shifted} - {2'b00, dvs_reg};
    assign take    = ~diff[NUM_W+1];

    always_comb
    begin
        rem_next      = rem_reg;
        quo_next      = quo_reg;
        dvs_next      = dvs_reg;
        zero_next     = zero_reg;
        res_next      = res_reg;
        res_zero_next = res_zero_reg;
        if (cmd.load)
        begin
            rem_next  = '0;
            quo_next  = in_data[NUM_W-1:0];
            dvs_next  = in_data[TDATA_W-1:NUM_W];
            zero_next = (in_data[TDATA_W-1:NUM_W] == '0);
        end
        else if (cmd.step)
        begin
            rem_next = take ? diff[NUM_W-1:0] : shifted[NUM_W-1:0];
            quo_next = {quo_reg[NUM_W-2:0], take};
        end
        if (cmd.out_load)
        begin
            res_next      = zero_reg ? '0 : {rem_reg, quo_reg};
            res_zero_next = zero_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg      <= rem_next;
        quo_reg      <= quo_next;
        dvs_reg      <= dvs_next;
        zero_reg     <= zero_next;
        res_reg      <= res_next;
        res_zero_reg <= res_zero_next;
    end

    assign out_data = res_reg;
    assign out_zero = res_zero_reg;

endmodule

// File: src/udiv128_ctrl.sv
// controller of the divider: step sequencing and output register handshake
// depends on udiv128_pkg
`timescale 1ns / 1ps

module udiv128_ctrl
    import udiv128_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_ready,
    output logic         out_valid,
    input  logic         out_ready,
    output udiv128_cmd_t cmd
);

    udiv128_state_t   state_reg;
    udiv128_state_t   state_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic             out_valid_reg;
    logic             out_valid_next;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            ST_IDLE:
            begin
                cnt_next = '0;
                if (in_valid)
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == LAST_STEP)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                // no item is taken while reset is held
                in_ready = rst_n;
                cmd.load = in_valid && rst_n;
            end
            ST_RUN:
            begin
                cmd.step = 1'b1;
            end
            ST_DONE:
            begin
                cmd.out_load = !out_valid_reg || out_ready;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

// File: sim/udiv128_quotient_remainder_tb.sv
// testbench for udiv128_quotient_remainder: directed and random 128-bit divisions
// checks quotient, remainder and zero-divisor flag against native 128-bit division
// depends on udiv128_pkg and udiv128_quotient_remainder
`timescale 1ns / 1ps

module udiv128_quotient_remainder_tb;
    import udiv128_pkg::*;

    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int RANDOM_ITEMS = 1200;
    localparam int HOLD_CYCLES  = 1500;
    localparam int DRAIN_CYCLES = 300;

    typedef struct packed {
        logic [WORD_W-1:0] quotient_low;
        logic [WORD_W-1:0] quotient_high;
        logic [WORD_W-1:0] remainder_low;
        logic [WORD_W-1:0] remainder_high;
        logic              zero_divisor;
    } div_result_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               s_axis_tvalid = 1'b0;
    logic               s_axis_tready;
    logic [TDATA_W-1:0] s_axis_tdata = '0;
    logic               m_axis_tvalid;
    logic               m_axis_tready = 1'b0;
    logic [TDATA_W-1:0] m_axis_tdata;
    logic               m_axis_tuser;

    logic [TDATA_W-1:0] operand_queue[$];
    div_result_t        expected_divisions[$];

    int  items_sent = 0;
    int  results_seen = 0;
    int  mismatches = 0;
    int  cycles = 0;
    int  hold_left = 0;
    bit  hold_done = 1'b0;

    udiv128_quotient_remainder DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    function automatic div_result_t divide_u128(logic [TDATA_W-1:0] operands);
        logic [NUM_W-1:0] dividend;
        logic [NUM_W-1:0] divisor;
        logic [NUM_W-1:0] quo;
        logic [NUM_W-1:0] rem;
        div_result_t      res;
        dividend = operands[NUM_W-1:0];
        divisor  = operands[TDATA_W-1:NUM_W];
        if (divisor == '0)
        begin
            quo = '0;
            rem = '0;
            res.zero_divisor = 1'b1;
        end
        else
        begin
            quo = dividend / divisor;
            rem = dividend % divisor;
            res.zero_divisor = 1'b0;
        end
        res.quotient_low   = quo[WORD_W-1:0];
        res.quotient_high  = quo[NUM_W-1:WORD_W];
        res.remainder_low  = rem[WORD_W-1:0];
        res.remainder_high = rem[NUM_W-1:WORD_W];
        return res;
    endfunction

    // random value of up to nbits significant bits, top bit set when nbits > 0
    function automatic logic [NUM_W-1:0] random_wide(int nbits);
        logic [NUM_W-1:0] v;
        v = {$urandom, $urandom, $urandom, $urandom};
        if (nbits == 0)
            v = '0;
        else if (nbits < NUM_W)
        begin
            v = v & ((NUM_W'(1) << nbits) - NUM_W'(1));
            v[nbits-1] = 1'b1;
        end
        else
            v[NUM_W-1] = 1'b1;
        return v;
    endfunction

    task automatic queue_division(logic [NUM_W-1:0] dividend, logic [NUM_W-1:0] divisor);
        operand_queue.push_back({divisor, dividend});
    endtask

    // sender
    always @(posedge clk)
    begin
        if (!rst_n)
            s_axis_tvalid <= 1'b0;
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                expected_divisions.push_back(divide_u128(s_axis_tdata));
                items_sent <= items_sent + 1;
            end
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (operand_queue.size() != 0 &&
                    ((items_sent >= 500 && items_sent < 700) || $urandom_range(99) >= 6))
                begin
                    s_axis_tdata  <= operand_queue.pop_front();
                    s_axis_tvalid <= 1'b1;
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    // long receiver hold-off so the block fills and stalls its input
    always @(posedge clk)
    begin
        if (hold_left > 0)
            hold_left <= hold_left - 1;
        else if (!hold_done && results_seen == 150)
        begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
    end

    // receiver and checker
    always @(posedge clk)
    begin
        div_result_t got;
        div_result_t want;
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.quotient_low   = m_axis_tdata[WORD_W-1:0];
                got.quotient_high  = m_axis_tdata[2*WORD_W-1:WORD_W];
                got.remainder_low  = m_axis_tdata[3*WORD_W-1:2*WORD_W];
                got.remainder_high = m_axis_tdata[4*WORD_W-1:3*WORD_W];
                got.zero_divisor   = m_axis_tuser;
                results_seen <= results_seen + 1;
                if (expected_divisions.size() == 0)
                begin
                    mismatches = mismatches + 1;
                    if (mismatches <= 10)
                        $display("unexpected result item: q=%h_%h r=%h_%h zero=%b",
                                 got.quotient_high, got.quotient_low,
                                 got.remainder_high, got.remainder_low, got.zero_divisor);
                end
                else
                begin
                    want = expected_divisions.pop_front();
                    if (got.quotient_low !== want.quotient_low ||
                        got.quotient_high !== want.quotient_high ||
                        got.remainder_low !== want.remainder_low ||
                        got.remainder_high !== want.remainder_high ||
                        got.zero_divisor !== want.zero_divisor)
                    begin
                        mismatches = mismatches + 1;
                        if (mismatches <= 10)
                        begin
                            $display("mismatch on result %0d:", results_seen);
                            $display("  expected q=%h_%h r=%h_%h zero=%b",
                                     want.quotient_high, want.quotient_low,
                                     want.remainder_high, want.remainder_low,
                                     want.zero_divisor);
                            $display("  actual   q=%h_%h r=%h_%h zero=%b",
                                     got.quotient_high, got.quotient_low,
                                     got.remainder_high, got.remainder_low,
                                     got.zero_divisor);
                        end
                    end
                end
            end
            if (hold_left > 0)
                m_axis_tready <= 1'b0;
            else if (results_seen >= 500 && results_seen < 700)
                m_axis_tready <= 1'b1;
            else
                m_axis_tready <= ($urandom_range(99) >= 6);
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial
    begin
        logic [NUM_W-1:0] all_ones;
        logic [NUM_W-1:0] top_bit;
        logic [NUM_W-1:0] dividend;
        logic [NUM_W-1:0] divisor;
        int               pick;
        all_ones = '1;
        top_bit  = NUM_W'(1) << (NUM_W - 1);

        // extremes, zero divisor, dividend below divisor, divisor with top bit set
        queue_division('0, '0);
        queue_division(all_ones, '0);
        queue_division('0, all_ones);
        queue_division(all_ones, all_ones);
        queue_division(all_ones, NUM_W'(1));
        queue_division('0, NUM_W'(1));
        queue_division(all_ones, top_bit);
        queue_division(top_bit - NUM_W'(1), top_bit);
        queue_division(all_ones, top_bit | NUM_W'(1));
        queue_division(all_ones - NUM_W'(1), all_ones);
        queue_division(NUM_W'(5), NUM_W'(7));
        queue_division(all_ones, NUM_W'(64'hffff_ffff_ffff_ffff));
        queue_division(all_ones, NUM_W'(1) << WORD_W);
        queue_division(all_ones, NUM_W'(32'hffff_ffff));
        queue_division({64'hffff_ffff_ffff_ffff, 64'h0}, NUM_W'(3));
        queue_division(NUM_W'(64'hffff_ffff_ffff_ffff), {64'h1, 64'h0});
        queue_division(top_bit, NUM_W'(2));
        queue_division({64'h8000_0000_0000_0000, 64'h0}, {64'h8000_0000_0000_0000, 64'h0});
        queue_division(NUM_W'(12345), '0);
        queue_division({$urandom, $urandom, $urandom, $urandom}, NUM_W'(10));

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            pick = $urandom_range(99);
            dividend = random_wide($urandom_range(NUM_W));
            if (pick < 4)
                divisor = '0;
            else if (pick < 16)
                divisor = random_wide(NUM_W);
            else if (pick < 40)
                divisor = {$urandom, $urandom, $urandom, $urandom};
            else
                divisor = random_wide($urandom_range(NUM_W, 1));
            if ($urandom_range(9) == 0)
                dividend = {$urandom, $urandom, $urandom, $urandom};
            queue_division(dividend, divisor);
        end

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        while (operand_queue.size() != 0 || s_axis_tvalid)
            @(posedge clk);
        while (expected_divisions.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
